FILE: rtl/pf2argb_pkg.sv
package pf2argb_pkg;

	// Source format codes of the configuration register.
	localparam logic [2:0] FMT_BGRA8   = 3'd0;
	localparam logic [2:0] FMT_RGB10A2 = 3'd1;
	localparam logic [2:0] FMT_RGBA16  = 3'd2;
	localparam logic [2:0] FMT_RGBA8   = 3'd3;

	// Conversion kind that travels down the pipeline with each pixel.
	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_R10  = 2'd1,
		KIND_R16  = 2'd2,
		KIND_SWAP = 2'd3
	} kind_t;

	// Rounding offsets for the scale-to-8-bit arithmetic.
	localparam logic [17:0] RND10 = 18'd511;
	localparam logic [23:0] RND16 = 24'd32767;

endpackage

FILE: rtl/pixel_format_to_argb8888.sv
// A request accepted at a clock edge passes the stage 1, stage 2 and stage 3 registers before its result strobe.
// Throughput: one pixel per clock, set by the three-stage conversion pipeline.
// The receiver cannot stall, so busy stays low and the pipeline never holds.
// Reset clears the stage valid bits and sets the source format to BGRA8.
module pixel_format_to_argb8888 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] pixel_word,
	output logic        done,
	output logic [31:0] argb_pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  source_format
);

	logic [2:0] fmt_q;

	logic                 valid_s1;
	logic [63:0]          pixel_s1;
	pf2argb_pkg::kind_t   kind_s1;

	logic                 valid_s2;
	pf2argb_pkg::kind_t   kind_s2;
	logic [31:0]          pass_s2;
	logic                 alpha10_s2;
	logic [3:0][23:0]     sum16_s2;
	logic [2:0][17:0]     sum10_s2;

	logic                 valid_s3;
	pf2argb_pkg::kind_t   kind_s3;
	logic [31:0]          argb_s3;

	pf2argb_pkg::kind_t   kind_d;
	logic [31:0]          pass_d;
	logic [3:0][23:0]     sum16_d;
	logic [2:0][17:0]     sum10_d;
	logic [31:0]          argb_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= pf2argb_pkg::FMT_BGRA8;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= source_format;
		end
	end

	// Decode the format into a conversion kind; unknown codes pass through.
	always_comb begin
		unique case (fmt_q)
			pf2argb_pkg::FMT_RGB10A2: kind_d = pf2argb_pkg::KIND_R10;
			pf2argb_pkg::FMT_RGBA16:  kind_d = pf2argb_pkg::KIND_R16;
			pf2argb_pkg::FMT_RGBA8:   kind_d = pf2argb_pkg::KIND_SWAP;
			default:                  kind_d = pf2argb_pkg::KIND_PASS;
		endcase
	end

	// Stage 1: capture the pixel and its conversion kind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pixel_s1 <= pixel_word;
			kind_s1  <= kind_d;
		end
	end

	// Channel times 255 plus the rounding offset, for each channel independently.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum16_d[i] = ({pixel_s1[16*i +: 16], 8'h00} - {8'h00, pixel_s1[16*i +: 16]})
				+ pf2argb_pkg::RND16;
		end
		for (int i = 0; i < 3; i++) begin
			sum10_d[i] = ({pixel_s1[10*i +: 10], 8'h00} - {8'h00, pixel_s1[10*i +: 10]})
				+ pf2argb_pkg::RND10;
		end
	end

	// Byte-level formats: red/blue swap or forced opaque alpha.
	always_comb begin
		if (kind_s1 == pf2argb_pkg::KIND_SWAP) begin
			pass_d = {pixel_s1[31:24], pixel_s1[7:0], pixel_s1[15:8], pixel_s1[23:16]};
		end else begin
			pass_d = {8'hFF, pixel_s1[23:0]};
		end
	end

	// Stage 2: scaled sums and the byte-level result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2    <= kind_s1;
			pass_s2    <= pass_d;
			alpha10_s2 <= |pixel_s1[31:30];
			sum16_s2   <= sum16_d;
			sum10_s2   <= sum10_d;
		end
	end

	// Take the high bits of each sum and pack alpha, red, green, blue; other kinds pass the byte-level result.
	always_comb begin
		case (kind_s2)
			pf2argb_pkg::KIND_R10: begin
				argb_d = {{8{alpha10_s2}}, sum10_s2[0][17:10], sum10_s2[1][17:10],
					sum10_s2[2][17:10]};
			end
			pf2argb_pkg::KIND_R16: begin
				argb_d = {sum16_s2[3][23:16], sum16_s2[0][23:16], sum16_s2[1][23:16],
					sum16_s2[2][23:16]};
			end
			default: begin
				argb_d = pass_s2;
			end
		endcase
	end

	// Stage 3: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			kind_s3 <= kind_s2;
			argb_s3 <= argb_d;
		end
	end

	assign done       = valid_s3;
	assign argb_pixel = argb_s3;

`ifndef SYNTHESIS
	// Every accepted request yields its result after the stage 1, stage 2 and stage 3 registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three cycles after request");

	// No result appears without a matching earlier request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without matching request");

	// The 2-bit alpha of the 10-bit format expands to fully clear or fully opaque.
	a_r10_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind_s3 == pf2argb_pkg::KIND_R10) |->
		(argb_pixel[31:24] == 8'h00 || argb_pixel[31:24] == 8'hFF))
		else $error("10-bit format alpha not binary");

	// Pass-through formats always come out opaque.
	a_pass_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind_s3 == pf2argb_pkg::KIND_PASS) |-> argb_pixel[31:24] == 8'hFF)
		else $error("pass-through alpha not opaque");
`endif

endmodule

FILE: verif/pixel_format_to_argb8888_tb.sv
module pixel_format_to_argb8888_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Format codes that the package leaves unnamed; all of them act as "other".
	localparam logic [2:0] FMT_OTHER  = 3'd4;
	localparam logic [2:0] FMT_SPARE5 = 3'd5;
	localparam logic [2:0] FMT_SPARE6 = 3'd6;
	localparam logic [2:0] FMT_SPARE7 = 3'd7;

	localparam int ITEM_TARGET = 1850;
	localparam int IDLE_PCT    = 17;
	localparam int DRAIN_WAIT  = 8;

	// Predicts the converted pixel for each request and checks results in order.
	class argb_scoreboard;
		logic [31:0] expected_argb[$];
		int unsigned mismatches;
		int unsigned matched;

		function new();
			mismatches = 0;
			matched = 0;
		endfunction

		// 10-bit channel to 8 bits with rounding.
		function logic [7:0] scale_from10(logic [9:0] c);
			logic [31:0] t;
			t = 32'(c) * 32'd255 + 32'd511;
			return t[17:10];
		endfunction

		// 16-bit channel to 8 bits with rounding.
		function logic [7:0] scale_from16(logic [15:0] c);
			logic [31:0] t;
			t = 32'(c) * 32'd255 + 32'd32767;
			return t[23:16];
		endfunction

		function logic [31:0] convert_pixel(logic [2:0] fmt, logic [63:0] w);
			logic [31:0] lo;
			lo = w[31:0];
			case (fmt)
				pf2argb_pkg::FMT_RGB10A2: begin
					return {(lo[31:30] != 2'b00) ? 8'hFF : 8'h00, scale_from10(lo[9:0]),
						scale_from10(lo[19:10]), scale_from10(lo[29:20])};
				end
				pf2argb_pkg::FMT_RGBA16: begin
					return {scale_from16(w[63:48]), scale_from16(w[15:0]),
						scale_from16(w[31:16]), scale_from16(w[47:32])};
				end
				pf2argb_pkg::FMT_RGBA8: begin
					return {lo[31:24], lo[7:0], lo[15:8], lo[23:16]};
				end
				default: begin
					return {8'hFF, lo[23:0]};
				end
			endcase
		endfunction

		function void note_request(logic [2:0] fmt, logic [63:0] w);
			expected_argb.insert(expected_argb.size(), convert_pixel(fmt, w));
		endfunction

		function void check_pixel(logic [31:0] actual);
			logic [31:0] want;
			if (expected_argb.size() == 0) begin
				$error("argb_pixel: unexpected result %h with no request pending", actual);
				mismatches++;
			end else begin
				want = expected_argb.pop_front();
				if (want !== actual) begin
					$error("argb_pixel mismatch: expected %h, actual %h", want, actual);
					mismatches++;
				end else begin
					matched++;
				end
			end
		endfunction

		function int pending();
			return expected_argb.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [63:0] pixel_word = '0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  source_format = pf2argb_pkg::FMT_BGRA8;
	logic        busy;
	logic        done;
	logic [31:0] argb_pixel;
	logic        cfg_ready;

	argb_scoreboard sb = new();
	logic [2:0]  model_format = pf2argb_pkg::FMT_BGRA8;
	logic        no_gaps = 1'b0;
	int unsigned requests_by_fmt[8];
	int unsigned format_writes = 0;

	pixel_format_to_argb8888 dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_word(pixel_word),
		.done(done),
		.argb_pixel(argb_pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.source_format(source_format)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watch both handshakes and the result strobe at every rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				model_format = source_format;
				format_writes++;
			end
			if (start && !busy) begin
				sb.note_request(model_format, pixel_word);
				requests_by_fmt[model_format]++;
			end
			if (done) begin
				sb.check_pixel(argb_pixel);
			end
		end
	end

	// A random pause between requests unless the current phase runs without gaps.
	// Each extra idle cycle is drawn on its own, so about 17 percent of cycles stay idle.
	function automatic int gap_cycles();
		int gap;
		gap = 0;
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			gap++;
		end
		return gap;
	endfunction

	task automatic send_pixel(logic [63:0] w);
		int gap;
		start <= 1'b1;
		pixel_word <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		gap = gap_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Format changes go in only once every pending pixel has come out.
	task automatic write_format(logic [2:0] fmt);
		int gap;
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		gap = gap_cycles();
		repeat (gap) @(posedge clk);
		cfg_valid <= 1'b1;
		source_format <= fmt;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly full random words, with some sparse and dense ones to hit channel extremes.
	function automatic logic [63:0] random_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: w = w & {$urandom, $urandom} & {$urandom, $urandom};
			1: w = w | {$urandom, $urandom} | {$urandom, $urandom};
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int total;
		int phase;
		int n;
		total = 0;
		phase = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset format first, then every code with its corner words.
		send_pixel(64'h0000_0000_0000_0000);
		send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
		send_pixel(64'h1234_5678_9ABC_DEF0);

		write_format(pf2argb_pkg::FMT_RGB10A2);
		send_pixel(64'h0000_0000_0000_0000);
		send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
		send_pixel(64'h0000_0000_4000_0000);
		send_pixel(64'h0000_0000_8010_0C02);
		send_pixel(64'hABCD_0000_3FF0_03FF);

		write_format(pf2argb_pkg::FMT_RGBA16);
		send_pixel(64'h0000_0000_0000_0000);
		send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
		send_pixel(64'h0080_0081_0080_0081);
		send_pixel(64'h7FFF_8000_8080_7F7F);

		write_format(pf2argb_pkg::FMT_RGBA8);
		send_pixel(64'h0000_0000_0000_0000);
		send_pixel(64'hFFFF_FFFF_FFFF_FFFF);
		send_pixel(64'hFFFF_FFFF_1122_3344);
		send_pixel(64'h0000_0000_00AA_55CC);

		write_format(FMT_OTHER);
		send_pixel(64'h5555_5555_00AB_CDEF);
		write_format(FMT_SPARE5);
		send_pixel(64'hF0F0_F0F0_0F0F_0F0F);
		write_format(FMT_SPARE6);
		send_pixel(64'h8000_0001_7FFF_FFFE);
		write_format(FMT_SPARE7);
		send_pixel(64'h0000_0000_1234_5678);
		send_pixel(64'hFFFF_FFFF_0000_0000);

		// Random phases, each under a random format; one phase runs with no gaps.
		while (total < ITEM_TARGET) begin
			n = $urandom_range(60, 180);
			if (n > ITEM_TARGET - total) begin
				n = ITEM_TARGET - total;
			end
			no_gaps = (phase == 2);
			write_format(3'($urandom_range(0, 7)));
			repeat (n) send_pixel(random_word());
			total += n;
			phase++;
		end
		no_gaps = 1'b0;

		// Drain the pipeline, then keep watching for stray strobes.
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Converted %0d pixels across %0d format writes, codes 0 to 7 all used.",
			sb.matched + sb.mismatches, format_writes);
		$display("Pixels per code: %0d %0d %0d %0d %0d %0d %0d %0d",
			requests_by_fmt[0], requests_by_fmt[1], requests_by_fmt[2], requests_by_fmt[3],
			requests_by_fmt[4], requests_by_fmt[5], requests_by_fmt[6], requests_by_fmt[7]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
